// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the Sv39 page table walker.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/sv39ptw_pkg.sv =====
// Package for the Sv39 page table walker: codes, field widths and shared types.
// It depends on nothing else.
package sv39ptw_pkg;

    localparam int PPN_W = 44;
    localparam int VPN_W = 27;
    localparam int ADDR_W = 56;
    localparam int STATUS_W = 3;
    localparam int IDX_W = 9;

    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic OUT_READ = 1'b0;
    localparam logic OUT_RESULT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USER = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BUSY = 3'd4;

    localparam logic [1:0] LEVEL0 = 2'd0;
    localparam logic [1:0] LEVEL1 = 2'd1;
    localparam logic [1:0] LEVEL2 = 2'd2;

    localparam int PTE_V_BIT = 0;
    localparam int PTE_U_BIT = 4;

    typedef struct packed {
        logic             busy;
        logic [1:0]       level;
        logic [VPN_W-1:0] vpn;
    } walk_state_t;

    typedef struct packed {
        logic                valid;
        logic                out_kind;
        logic [ADDR_W-1:0]   mem_address;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   paddr;
    } walk_result_t;

endpackage

// ===== sv/sv39ptw_step.sv =====
// Combinational decision for one transaction of the Sv39 page table walker.
// It computes the result and the next walk state; it depends on sv39ptw_pkg.
module sv39ptw_step
    import sv39ptw_pkg::*;
(
    input  walk_state_t        state_cur,
    input  logic [PPN_W-1:0]   root_page_number,
    input  logic               kind,
    input  logic [63:0]        vaddr,
    input  logic [63:0]        mem_data,
    output walk_state_t        state_next,
    output walk_result_t       result
);

    logic [PPN_W-1:0] table_ppn;
    logic [PPN_W-1:0] pte_ppn;
    logic [1:0]       read_level;
    logic [VPN_W-1:0] read_vpn;
    logic [IDX_W-1:0] read_idx;
    logic [ADDR_W-1:0] read_address;

    assign pte_ppn = mem_data[PPN_W+9:10];

    assign table_ppn = (kind == KIND_TRANSLATE) ? root_page_number : pte_ppn;
    assign read_level = (kind == KIND_TRANSLATE) ? LEVEL2 : state_cur.level - 2'd1;
    assign read_vpn = (kind == KIND_TRANSLATE) ? vaddr[VPN_W+11:12] : state_cur.vpn;

    always_comb
    begin
        read_idx = read_vpn[IDX_W-1:0];
        unique case (read_level)
            LEVEL2: read_idx = read_vpn[3*IDX_W-1:2*IDX_W];
            LEVEL1: read_idx = read_vpn[2*IDX_W-1:IDX_W];
            default: read_idx = read_vpn[IDX_W-1:0];
        endcase
    end

    assign read_address = {table_ppn, read_idx, 3'b000};

    always_comb
    begin
        state_next = state_cur;
        result = '0;
        if (kind == KIND_TRANSLATE)
        begin
            result.valid = 1'b1;
            result.out_kind = OUT_RESULT;
            if (state_cur.busy)
            begin
                result.status = STATUS_BUSY;
            end
            else if (|vaddr[63:38])
            begin
                result.status = STATUS_RANGE;
            end
            else
            begin
                state_next.busy = 1'b1;
                state_next.level = LEVEL2;
                state_next.vpn = vaddr[VPN_W+11:12];
                result.out_kind = OUT_READ;
                result.mem_address = read_address;
            end
        end
        else if (state_cur.busy)
        begin
            result.valid = 1'b1;
            result.out_kind = OUT_RESULT;
            if (!mem_data[PTE_V_BIT])
            begin
                state_next.busy = 1'b0;
                state_next.level = LEVEL0;
                result.status = STATUS_INVALID;
            end
            else if (state_cur.level != LEVEL0)
            begin
                state_next.level = read_level;
                result.out_kind = OUT_READ;
                result.mem_address = read_address;
            end
            else
            begin
                state_next.busy = 1'b0;
                state_next.level = LEVEL0;
                if (!mem_data[PTE_U_BIT])
                begin
                    result.status = STATUS_NOT_USER;
                end
                else
                begin
                    result.status = STATUS_OK;
                    result.paddr = {pte_ppn, 12'h000};
                end
            end
        end
    end

endmodule

// ===== sv/sv39_page_table_walker.sv =====
// Sv39 page table walker. A transaction is accepted on any cycle in which in_stall is low: one
// transaction per cycle, with its result (a read request or a final translation result) in the
// output register, or in the skid register while the output stalls. Decision and entry address
// come from a single pass of logic through sv39ptw_step; a one-entry skid register behind the
// output register lets the block keep accepting while a result waits, and in_stall rises only
// when both hold a result. Write root_page_number only while no walk is in progress.
`include "assert_macros.svh"

module sv39_page_table_walker
    import sv39ptw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PPN_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [63:0]         vaddr,
    input  logic [63:0]         mem_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_kind,
    output logic [ADDR_W-1:0]   mem_address,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   paddr
);

    logic [PPN_W-1:0] root_reg;
    walk_state_t      state_reg;
    walk_state_t      state_next;
    walk_result_t     step_result;
    walk_result_t     out_reg;
    walk_result_t     skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_accept;
    logic             push;
    logic             out_pop;

    sv39ptw_step u_step (
        .state_cur        (state_reg),
        .root_page_number (root_reg),
        .kind             (kind),
        .vaddr            (vaddr),
        .mem_data         (mem_data),
        .state_next       (state_next),
        .result           (step_result)
    );

    assign in_stall = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign push = in_accept && step_result.valid;
    assign out_pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
        end
        else if (cfg_we)
        begin
            root_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_reg <= step_result;
            end
            else
            begin
                out_reg <= step_result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind = out_reg.out_kind;
    assign mem_address = out_reg.mem_address;
    assign status = out_reg.status;
    assign paddr = out_reg.paddr;

    `ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_SAME(a_idle_level_zero, clk, rst_n, !state_reg.busy, state_reg.level == LEVEL0)
    `ASSERT_NEXT(a_busy_reject_seen, clk, rst_n, in_accept && kind == KIND_TRANSLATE && state_reg.busy, out_valid_reg)
    `ASSERT_NEXT(a_idle_response_ignored, clk, rst_n, in_accept && kind == KIND_RESPONSE && !state_reg.busy, !state_reg.busy)

endmodule
